@@ sv/pfac_pkg.sv @@
// ----------------------------------------------------------------------------
// pfac_pkg
// Shared types and fixed field widths of the per-flow ack coalescer.
// ----------------------------------------------------------------------------
package pfac_pkg;

   // fixed payload widths
   localparam int FLOW_ID_W = 8;
   localparam int ACK_NO_W  = 16;
   localparam int STATUS_W  = 3;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_STORED    = 3'd0,
      STATUS_COALESCED = 3'd1,
      STATUS_DROPPED   = 3'd2,
      STATUS_POPPED    = 3'd3,
      STATUS_EMPTY     = 3'd4,
      STATUS_RANGE     = 3'd5
   } status_type;

   // request kinds
   typedef enum logic {
      ACTION_ADD    = 1'b0,
      ACTION_REMOVE = 1'b1
   } action_type;

   // top-level control states, one-hot
   typedef enum logic [1:0] {
      CTRL_CLEAR = 2'b01,
      CTRL_RUN   = 2'b10
   } ctrl_state_type;

endpackage

@@ sv/pfac_ram.sv @@
// ----------------------------------------------------------------------------
// pfac_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module pfac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/per_flow_ack_coalescer.sv @@
// ----------------------------------------------------------------------------
// per_flow_ack_coalescer
// Keeps one pending ack number per flow and a LIFO stack of pending flows.
// ----------------------------------------------------------------------------
// Registers: a request stage, then a result register; a result stall holds the
// request stage. Throughput: one request per cycle unless results stall or the
// clearing pass runs; the slot and stack RAMs are read at accept and written
// when the request stage advances, with the latest write forwarded. Reset:
// synchronous; a clearing pass then zeroes the slot table, with req_tready low.
module per_flow_ack_coalescer
   import pfac_pkg::*;
#(
   parameter int FLOWS    = 256,
   parameter int ACK_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] flow_id, [23:8] ack_no
   input  logic        req_tuser,   // [0] action
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_flow_id, [23:8] out_ack_no,
                                    // [24] have_pending, [31:25] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int FLOW_W  = $clog2(FLOWS);
   localparam int CNT_W   = $clog2(FLOWS + 1);
   localparam int SLOT_W  = 1 + FLOW_W + ACK_BITS;
   localparam int STACK_W = FLOW_W + ACK_BITS;

   typedef struct packed {
      logic                valid;
      logic [FLOW_W-1:0]   pos;
      logic [ACK_BITS-1:0] ack;
   } slot_type;

   typedef struct packed {
      logic [FLOW_W-1:0]   flow;
      logic [ACK_BITS-1:0] ack;
   } stack_entry_type;

   // control
   ctrl_state_type    state_ff, state_in;
   logic [FLOW_W-1:0] clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in, count_after;

   // request stage
   logic                 s1_valid_ff, s1_valid_in;
   action_type           s1_action_ff;
   logic [FLOW_ID_W-1:0] s1_flow_ff;
   logic [ACK_BITS-1:0]  s1_ack_ff;
   logic [FLOW_W-1:0]    s1_stk_addr_ff;

   // forwarding of the latest write to each ram
   logic              fwd_slot_en_ff, fwd_slot_en_in;
   logic [FLOW_W-1:0] fwd_slot_addr_ff;
   slot_type          fwd_slot_data_ff;
   logic              fwd_stk_en_ff, fwd_stk_en_in;
   logic [FLOW_W-1:0] fwd_stk_addr_ff;
   stack_entry_type   fwd_stk_data_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [FLOW_ID_W-1:0] rsp_flow_ff;
   logic [ACK_NO_W-1:0]  rsp_ack_ff;
   logic                 rsp_pending_ff;

   // ram ports
   logic              slot_we, stk_we;
   logic [FLOW_W-1:0] slot_waddr, stk_waddr;
   slot_type          slot_wdata;
   stack_entry_type   stk_wdata;
   logic [SLOT_W-1:0] slot_rd_raw;
   logic [STACK_W-1:0] stk_rd_raw;
   logic [FLOW_W-1:0] slot_raddr, stk_raddr;

   // compute
   logic              accept, advance, clearing;
   logic [FLOW_W-1:0] s1_idx;
   slot_type          slot_q;
   stack_entry_type   stk_q;
   logic [ACK_BITS-1:0] ack_diff;
   logic              later;
   logic              cmp_we_slot, cmp_we_stk;
   slot_type          cmp_slot_data;
   stack_entry_type   cmp_stk_data;
   logic [FLOW_W-1:0] cmp_slot_addr, cmp_stk_addr;
   status_type        status;
   logic [FLOW_ID_W-1:0] out_flow;
   logic [ACK_NO_W-1:0]  out_ack;

   // handshake
   assign clearing   = (state_ff == CTRL_CLEAR);
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clearing && (!s1_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;

   // read addresses launched at accept
   assign slot_raddr = FLOW_W'(req_tdata[7:0]);
   assign stk_raddr  = FLOW_W'(count_in - CNT_W'(1));

   pfac_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(FLOWS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_we),
      .wr_addr(slot_waddr),
      .wr_data(slot_wdata),
      .rd_en  (accept),
      .rd_addr(slot_raddr),
      .rd_data(slot_rd_raw)
   );

   pfac_ram #(
      .WIDTH(STACK_W),
      .DEPTH(FLOWS)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (stk_we),
      .wr_addr(stk_waddr),
      .wr_data(stk_wdata),
      .rd_en  (accept),
      .rd_addr(stk_raddr),
      .rd_data(stk_rd_raw)
   );

   // read data with the latest write forwarded
   assign s1_idx = FLOW_W'(s1_flow_ff);
   always_comb begin
      slot_q = slot_type'(slot_rd_raw);
      if (fwd_slot_en_ff && fwd_slot_addr_ff == s1_idx) begin
         slot_q = fwd_slot_data_ff;
      end
      stk_q = stack_entry_type'(stk_rd_raw);
      if (fwd_stk_en_ff && fwd_stk_addr_ff == s1_stk_addr_ff) begin
         stk_q = fwd_stk_data_ff;
      end
   end

   // serial comparison: later when the wrapped difference is nonzero and below half
   assign ack_diff = s1_ack_ff - slot_q.ack;
   assign later    = (ack_diff != '0) && !ack_diff[ACK_BITS-1];

   // per-request decision
   always_comb begin
      cmp_we_slot   = 1'b0;
      cmp_we_stk    = 1'b0;
      cmp_slot_addr = s1_idx;
      cmp_slot_data = '0;
      cmp_stk_addr  = count_ff[FLOW_W-1:0];
      cmp_stk_data  = '0;
      count_after   = count_ff;
      status        = STATUS_RANGE;
      out_flow      = '0;
      out_ack       = '0;
      if (s1_action_ff == ACTION_ADD) begin
         if (32'(s1_flow_ff) >= FLOWS) begin
            status = STATUS_RANGE;
         end else if (!slot_q.valid) begin
            if (count_ff >= CNT_W'(FLOWS)) begin
               status = STATUS_RANGE;
            end else begin
               cmp_we_slot        = 1'b1;
               cmp_slot_data.valid = 1'b1;
               cmp_slot_data.pos  = count_ff[FLOW_W-1:0];
               cmp_slot_data.ack  = s1_ack_ff;
               cmp_we_stk         = 1'b1;
               cmp_stk_data.flow  = s1_idx;
               cmp_stk_data.ack   = s1_ack_ff;
               count_after        = count_ff + CNT_W'(1);
               status             = STATUS_STORED;
            end
         end else if (later) begin
            cmp_we_slot         = 1'b1;
            cmp_slot_data.valid = 1'b1;
            cmp_slot_data.pos   = slot_q.pos;
            cmp_slot_data.ack   = s1_ack_ff;
            cmp_we_stk          = 1'b1;
            cmp_stk_addr        = slot_q.pos;
            cmp_stk_data.flow   = s1_idx;
            cmp_stk_data.ack    = s1_ack_ff;
            status              = STATUS_COALESCED;
         end else begin
            status = STATUS_DROPPED;
         end
      end else begin
         if (count_ff == '0) begin
            status = STATUS_EMPTY;
         end else begin
            // pop the top entry and clear its flow slot
            cmp_we_slot   = 1'b1;
            cmp_slot_addr = stk_q.flow;
            count_after   = count_ff - CNT_W'(1);
            out_flow      = FLOW_ID_W'(stk_q.flow);
            out_ack       = ACK_NO_W'(stk_q.ack);
            status        = STATUS_POPPED;
         end
      end
   end

   // ram write ports: clearing pass or committed request
   always_comb begin
      if (clearing) begin
         slot_we    = 1'b1;
         slot_waddr = clr_idx_ff;
         slot_wdata = '0;
      end else begin
         slot_we    = advance && cmp_we_slot;
         slot_waddr = cmp_slot_addr;
         slot_wdata = cmp_slot_data;
      end
      stk_we    = advance && cmp_we_stk;
      stk_waddr = cmp_stk_addr;
      stk_wdata = cmp_stk_data;
   end

   // next-state logic
   assign count_in       = advance ? count_after : count_ff;
   assign s1_valid_in    = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_tready);
   assign fwd_slot_en_in = slot_we || fwd_slot_en_ff;
   assign fwd_stk_en_in  = stk_we || fwd_stk_en_ff;

   // clearing pass sequencer
   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      unique case (state_ff)
         CTRL_CLEAR: begin
            clr_idx_in = clr_idx_ff + FLOW_W'(1);
            if (clr_idx_ff == FLOW_W'(FLOWS - 1)) begin
               state_in = CTRL_RUN;
            end
         end
         CTRL_RUN: begin
            state_in = CTRL_RUN;
         end
         default: begin
            state_in = CTRL_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= CTRL_CLEAR;
         clr_idx_ff     <= '0;
         count_ff       <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_slot_en_ff <= 1'b0;
         fwd_stk_en_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         count_ff       <= count_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         fwd_slot_en_ff <= fwd_slot_en_in;
         fwd_stk_en_ff  <= fwd_stk_en_in;
      end
   end

   // request stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff   <= action_type'(req_tuser);
         s1_flow_ff     <= req_tdata[7:0];
         s1_ack_ff      <= ACK_BITS'(req_tdata[23:8]);
         s1_stk_addr_ff <= stk_raddr;
      end
   end

   // forwarding payload
   always_ff @(posedge clock) begin
      if (slot_we) begin
         fwd_slot_addr_ff <= slot_waddr;
         fwd_slot_data_ff <= slot_wdata;
      end
      if (stk_we) begin
         fwd_stk_addr_ff <= stk_waddr;
         fwd_stk_data_ff <= stk_wdata;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff  <= status;
         rsp_flow_ff    <= out_flow;
         rsp_ack_ff     <= out_ack;
         rsp_pending_ff <= (count_after != '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'b0, rsp_pending_ff, rsp_ack_ff, rsp_flow_ff};

endmodule

@@ sim/pfac_checker.sv @@
// ----------------------------------------------------------------------------
// pfac_checker
// Watches both channels of the ack coalescer, keeps its own copy of the
// per-flow slots and the pending-flow stack, predicts one result per request
// and compares every returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module pfac_checker
   import pfac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] flow_id, [23:8] ack_no
   input  logic        req_tuser,   // [0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [7:0] out_flow_id, [23:8] out_ack_no,
                                    // [24] have_pending, [31:25] zero
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   output int          fail_count,
   output int          awaiting,
   output int          results_checked,
   output logic [5:0]  status_seen,
   output int          peak_depth
);

   localparam int FLOW_COUNT  = 256;
   localparam int REPORT_MAX  = 10;
   localparam logic [ACK_NO_W-1:0] HALF_RANGE = 16'h8000;

   typedef struct packed {
      status_type          status;
      logic [FLOW_ID_W-1:0] flow;
      logic [ACK_NO_W-1:0]  ack;
      logic                 pending;
      logic [6:0]           pad;
   } ack_outcome_type;

   // shadow of the block's flow table and pending stack
   logic                 pend_live  [FLOW_COUNT];
   logic [ACK_NO_W-1:0]  pend_ack   [FLOW_COUNT];
   logic [FLOW_ID_W-1:0] flow_stack [FLOW_COUNT];
   int                   stack_depth;

   ack_outcome_type outcome_q [$];

   // apply one request to the shadow state and return its result
   function automatic ack_outcome_type coalesce_step(action_type act,
                                                     logic [FLOW_ID_W-1:0] flow,
                                                     logic [ACK_NO_W-1:0] ack_in);
      ack_outcome_type      res;
      logic [ACK_NO_W-1:0]  ahead;
      logic [FLOW_ID_W-1:0] top_flow;
      res = '0;
      if (act == ACTION_ADD) begin
         ahead = ack_in - pend_ack[flow];
         if (int'(flow) >= FLOW_COUNT) begin
            res.status = STATUS_RANGE;
         end else if (!pend_live[flow]) begin
            if (stack_depth >= FLOW_COUNT) begin
               res.status = STATUS_RANGE;
            end else begin
               pend_live[flow]         = 1'b1;
               pend_ack[flow]          = ack_in;
               flow_stack[stack_depth] = flow;
               stack_depth++;
               if (stack_depth > peak_depth) peak_depth = stack_depth;
               res.status = STATUS_STORED;
            end
         end else if (ahead != '0 && ahead < HALF_RANGE) begin
            // serially later number replaces the held one
            pend_ack[flow] = ack_in;
            res.status     = STATUS_COALESCED;
         end else begin
            res.status = STATUS_DROPPED;
         end
      end else begin
         if (stack_depth == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            stack_depth--;
            top_flow            = flow_stack[stack_depth];
            res.flow            = top_flow;
            res.ack             = pend_ack[top_flow];
            pend_live[top_flow] = 1'b0;
            res.status          = STATUS_POPPED;
         end
      end
      res.pending = (stack_depth != 0);
      return res;
   endfunction

   // one result as text
   function automatic string outcome_text(ack_outcome_type o);
      return $sformatf("st %0d flow %0h ack %0h pend %0b pad %0h",
                       o.status, o.flow, o.ack, o.pending, o.pad);
   endfunction

   function automatic void report_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("mismatch: %s", msg);
   endfunction

   // predict on request accept, compare on result accept
   always @(posedge clock) begin : watch
      ack_outcome_type got;
      ack_outcome_type want;
      if (reset) begin
         for (int f = 0; f < FLOW_COUNT; f++) pend_live[f] = 1'b0;
         stack_depth = 0;
         outcome_q.delete();
         fail_count      = 0;
         results_checked = 0;
         status_seen     = '0;
         peak_depth      = 0;
      end else begin
         if (req_tvalid && req_tready)
            outcome_q.push_back(coalesce_step(action_type'(req_tuser),
                                              req_tdata[7:0], req_tdata[23:8]));
         if (rsp_tvalid && rsp_tready) begin
            got.status  = status_type'(rsp_tuser);
            got.flow    = rsp_tdata[7:0];
            got.ack     = rsp_tdata[23:8];
            got.pending = rsp_tdata[24];
            got.pad     = rsp_tdata[31:25];
            results_checked++;
            if (rsp_tuser < 3'd6) status_seen[rsp_tuser] = 1'b1;
            if (outcome_q.size() == 0) begin
               report_failure($sformatf("result with none due: %s", outcome_text(got)));
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status || got.flow !== want.flow ||
                   got.ack !== want.ack || got.pending !== want.pending ||
                   got.pad !== want.pad)
                  report_failure($sformatf("result %0d expected %s, got %s",
                                           results_checked, outcome_text(want),
                                           outcome_text(got)));
            end
         end
      end
      awaiting = outcome_q.size();
   end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the per-flow ack coalescer with directed corner requests, a full
// fill and drain of the pending stack begun under a long result stall, and random
// add/remove mixes; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   import pfac_pkg::*;

   localparam int CLK_PERIOD      = 8;
   localparam int RESET_CYCLES    = 5;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int LONG_HOLD       = 400;
   localparam int SEGMENTS        = 9;
   localparam int SEGMENT_ITEMS   = 100;
   localparam int SETTLE_CYCLES   = 8;
   localparam int FLOW_COUNT      = 256;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [7:0] flow_id, [23:8] ack_no
   logic        req_tuser  = 1'b0; // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [7:0] out_flow_id, [23:8] out_ack_no,
                                   // [24] have_pending, [31:25] zero
   logic [2:0]  rsp_tuser;         // [2:0] status

   int          fail_count;
   int          awaiting;
   int          results_checked;
   logic [5:0]  status_seen;
   int          peak_depth;

   int          sent_count  = 0;
   int          cycle_count = 0;
   bit          steady      = 1'b0;
   bit          hold_request = 1'b0;
   logic [15:0] last_ack [FLOW_COUNT];

   per_flow_ack_coalescer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pfac_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .awaiting        (awaiting),
      .results_checked (results_checked),
      .status_seen     (status_seen),
      .peak_depth      (peak_depth)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // ack number near the last one sent on this flow, or random, to hit every compare case
   function automatic logic [15:0] next_ack(logic [7:0] flow);
      logic [15:0] v;
      case ($urandom_range(0, 9))
         0:       v = last_ack[flow] + 16'd1;
         1:       v = last_ack[flow] + 16'($urandom_range(1, 200));
         2:       v = last_ack[flow] - 16'($urandom_range(0, 200));
         3:       v = last_ack[flow] + 16'h8000;
         4:       v = last_ack[flow] + 16'h7fff;
         5:       v = last_ack[flow];
         default: v = 16'($urandom);
      endcase
      last_ack[flow] = v;
      return v;
   endfunction

   // offer one request after a random gap (none in steady mode) and wait for its accept
   task automatic send_request(action_type act, logic [7:0] flow, logic [15:0] ack_in);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {ack_in, flow};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic send_remove();
      send_request(ACTION_REMOVE, 8'($urandom), 16'($urandom));
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      int  stall;
      bit  hold_taken;
      stall      = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall--;
            end
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[per_flow_ack_coalescer] ERROR");
      $finish;
   end

   // stimulus and verdict
   initial begin
      logic [7:0] order [FLOW_COUNT];
      logic [7:0] swap;
      logic [7:0] flow;
      int         j;
      int         remove_pct;
      int         span;

      for (int f = 0; f < FLOW_COUNT; f++) last_ack[f] = 16'($urandom);
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed corners: empty pop, equal, half-range, wrap, lifo order
      send_remove();
      send_request(ACTION_ADD, 8'd0, 16'h0000);
      send_request(ACTION_ADD, 8'd0, 16'h0000);
      send_request(ACTION_ADD, 8'd0, 16'h8000);
      send_request(ACTION_ADD, 8'd0, 16'h7fff);
      send_request(ACTION_ADD, 8'd0, 16'h0000);
      send_request(ACTION_ADD, 8'd255, 16'hffff);
      send_request(ACTION_ADD, 8'd255, 16'h0000);
      send_request(ACTION_ADD, 8'd255, 16'hfffe);
      send_request(ACTION_ADD, 8'haa, 16'h5555);
      send_request(ACTION_ADD, 8'h55, 16'haaaa);
      send_remove();
      send_remove();
      send_request(ACTION_ADD, 8'h55, 16'h1234);
      send_remove();
      send_remove();
      send_remove();
      send_remove();
      send_request(ACTION_ADD, 8'd1, 16'hffff);
      send_request(ACTION_ADD, 8'd1, 16'h7ffe);
      send_remove();

      // fill every flow, starting under a long hold-off of results, then drain past empty
      hold_request = 1'b1;
      for (int f = 0; f < FLOW_COUNT; f++) order[f] = 8'(f);
      for (int f = FLOW_COUNT - 1; f > 0; f--) begin
         j        = $urandom_range(0, f);
         swap     = order[f];
         order[f] = order[j];
         order[j] = swap;
      end
      for (int f = 0; f < FLOW_COUNT; f++) begin
         send_request(ACTION_ADD, order[f], next_ack(order[f]));
         if ($urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, f);
            send_request(ACTION_ADD, order[j], next_ack(order[j]));
         end
      end
      for (int f = 0; f <= FLOW_COUNT; f++) send_remove();

      // random mixes of adds and removes over narrow and wide flow ranges
      for (int s = 0; s < SEGMENTS; s++) begin
         steady = (s == 4);
         case ($urandom_range(0, 4))
            0:       remove_pct = 15;
            1:       remove_pct = 35;
            2:       remove_pct = 50;
            3:       remove_pct = 65;
            default: remove_pct = 85;
         endcase
         case ($urandom_range(0, 2))
            0:       span = 7;
            1:       span = 31;
            default: span = 255;
         endcase
         for (int k = 0; k < SEGMENT_ITEMS; k++) begin
            if ($urandom_range(0, 99) < remove_pct) begin
               send_remove();
            end else begin
               flow = 8'($urandom_range(0, span));
               send_request(ACTION_ADD, flow, next_ack(flow));
            end
         end
      end
      steady = 1'b0;

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("coalescer run: %0d requests, %0d results checked, deepest stack %0d",
               sent_count, results_checked, peak_depth);
      $display("status codes returned (bit per code, 5..0): %b", status_seen);
      if (fail_count == 0)
         $display("[per_flow_ack_coalescer] OK");
      else
         $display("[per_flow_ack_coalescer] ERROR");
      $finish;
   end

endmodule
